>>> src/icr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icr_pkg: shared types and constants for the in-order chunk reassembly check
// Event kinds, outcome codes, session phases and the word layouts of both
// stream channels.
// ----------------------------------------------------------------------------
package icr_pkg;

  // Field widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned TagW     = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned LenPortW = 16;
  localparam int unsigned OutcomeW = 3;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned RegW     = 32;
  localparam int unsigned CfgAddrW = 1;

  // Input word: session_tag, sequence_number, byte_offset, chunk_length, sink_ok
  localparam int unsigned InTagLsb  = 0;
  localparam int unsigned InSeqLsb  = InTagLsb + TagW;
  localparam int unsigned InOffLsb  = InSeqLsb + CountW;
  localparam int unsigned InLenLsb  = InOffLsb + CountW;
  localparam int unsigned InOkBit   = InLenLsb + LenPortW;
  localparam int unsigned InBits    = InOkBit + 1;
  localparam int unsigned InDataW   = ((InBits + 7) / 8) * 8;

  // Result word: outcome, session_state, bytes_received, next_sequence
  localparam int unsigned OutOutcomeLsb = 0;
  localparam int unsigned OutStateLsb   = OutOutcomeLsb + OutcomeW;
  localparam int unsigned OutBytesLsb   = OutStateLsb + PhaseW;
  localparam int unsigned OutSeqLsb     = OutBytesLsb + CountW;
  localparam int unsigned OutBits       = OutSeqLsb + CountW;
  localparam int unsigned OutDataW      = ((OutBits + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_TOTAL_LENGTH   = 1'd0;
  localparam logic [CfgAddrW-1:0] REG_CAPACITY_LIMIT = 1'd1;

  typedef enum logic [KindW-1:0] {
    KIND_START  = 2'd0,
    KIND_CHUNK  = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_ABORT  = 2'd3
  } kind_e;

  typedef enum logic [OutcomeW-1:0] {
    OC_ACCEPTED     = 3'd0,
    OC_NOT_ACTIVE   = 3'd1,
    OC_WRONG_TAG    = 3'd2,
    OC_OUT_OF_ORDER = 3'd3,
    OC_OVER_CAP     = 3'd4,
    OC_OVER_TOTAL   = 3'd5,
    OC_SINK_FAILED  = 3'd6,
    OC_LEN_MISMATCH = 3'd7
  } outcome_e;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_FAILED = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

endpackage : icr_pkg
`default_nettype wire

>>> src/inorder_chunk_reassembly_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inorder_chunk_reassembly_check: session checker for in-order upload chunks
// Tracks one upload session and reports a verdict word for every event word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries event words (kind in tuser; tag, sequence, offset, length
//   and the consumer's verdict in tdata). m_axis returns exactly one result
//   word per event: outcome, session phase, byte count and next sequence.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write total_length (index 0) and
//   capacity_limit (index 1); write them only while no event is in flight.
// Pipeline and throughput:
//   The event is held in the input register while the check logic feeds
//   the result register, from which the result word is presented. One event
//   per cycle is sustained while m_axis_tready stays high; the session state
//   updates in the same cycle the event leaves the input register, so
//   events back to back see each other's effect.
// Reset:
//   rst_ni clears the session to idle with tag and counters at zero, the
//   registers to zero and both stages to empty.
// Stall:
//   While m_axis_tready is low the result is held and one further event can
//   still be taken into the input register; after that s_axis_tready drops.
// ----------------------------------------------------------------------------
module inorder_chunk_reassembly_check #(
  parameter int unsigned CHUNK_LENGTH_BITS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Event stream
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: session_tag[31:0], sequence_number[63:32], byte_offset[95:64],
  //        chunk_length[111:96], sink_ok[112], zero pad[119:113]
  input  wire  [icr_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: kind[1:0]
  input  wire  [icr_pkg::KindW-1:0]     s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // tdata: outcome[2:0], session_state[4:3], bytes_received[36:5],
  //        next_sequence[68:37], zero pad[71:69]
  output logic [icr_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration write port
  input  wire                           cfg_we_i,
  input  wire  [icr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire  [icr_pkg::RegW-1:0]      cfg_wdata_i
);
  import icr_pkg::*;

  // Only the low bits of the length field count
  localparam int unsigned LenW =
      (CHUNK_LENGTH_BITS < LenPortW) ? CHUNK_LENGTH_BITS : LenPortW;

  // Configuration registers
  logic [RegW-1:0] total_q, cap_q;

  // Input register
  logic                in_valid_q;
  logic [InBits-1:0]   in_word_q;
  kind_e               in_kind_q;

  // Session state
  phase_e              phase_q, phase_d;
  logic [TagW-1:0]     tag_q, tag_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0]   seq_q, seq_d;

  // Result register
  logic                out_valid_q;
  outcome_e            outcome_q, outcome_d;
  phase_e              res_phase_q;
  logic [CountW-1:0]   res_cnt_q, res_seq_q;

  // Handshake
  logic advance, process;

  // Decoded event fields
  logic [TagW-1:0]     ev_tag;
  logic [CountW-1:0]   ev_seq, ev_off, ev_len;
  logic                ev_ok;
  logic [CountW:0]     end_pos;
  logic                over_cap, over_tot;

  assign advance       = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      cap_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TOTAL_LENGTH:   total_q <= cfg_wdata_i;
        REG_CAPACITY_LIMIT: cap_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata[InBits-1:0];
      in_kind_q <= kind_e'(s_axis_tuser);
    end
  end

  // Unpack the held event
  assign ev_tag   = in_word_q[InTagLsb +: TagW];
  assign ev_seq   = in_word_q[InSeqLsb +: CountW];
  assign ev_off   = in_word_q[InOffLsb +: CountW];
  assign ev_len   = CountW'(in_word_q[InLenLsb +: LenW]);
  assign ev_ok    = in_word_q[InOkBit];
  assign end_pos  = {1'b0, cnt_q} + {1'b0, ev_len};
  assign over_cap = end_pos > {1'b0, cap_q};
  assign over_tot = (total_q != '0) && (end_pos > {1'b0, total_q});

  // Check the event against the session
  always_comb begin
    phase_d   = phase_q;
    tag_d     = tag_q;
    cnt_d     = cnt_q;
    seq_d     = seq_q;
    outcome_d = OC_ACCEPTED;
    unique case (in_kind_q)
      KIND_START: begin
        phase_d = PH_ACTIVE;
        tag_d   = ev_tag;
        cnt_d   = '0;
        seq_d   = '0;
      end
      KIND_CHUNK: begin
        priority if (phase_q != PH_ACTIVE) begin
          outcome_d = OC_NOT_ACTIVE;
        end else if (ev_tag != tag_q) begin
          outcome_d = OC_WRONG_TAG;
        end else if (ev_seq != seq_q || ev_off != cnt_q) begin
          outcome_d = OC_OUT_OF_ORDER;
        end else if (over_cap) begin
          outcome_d = OC_OVER_CAP;
          phase_d   = PH_FAILED;
        end else if (over_tot) begin
          outcome_d = OC_OVER_TOTAL;
          phase_d   = PH_FAILED;
        end else if (ev_len != '0 && !ev_ok) begin
          outcome_d = OC_SINK_FAILED;
          phase_d   = PH_FAILED;
        end else begin
          cnt_d = end_pos[CountW-1:0];
          seq_d = seq_q + CountW'(1);
        end
      end
      KIND_FINISH: begin
        priority if (phase_q != PH_ACTIVE) begin
          outcome_d = OC_NOT_ACTIVE;
        end else if (ev_tag != tag_q) begin
          outcome_d = OC_WRONG_TAG;
        end else if (total_q != '0 && cnt_q != total_q) begin
          outcome_d = OC_LEN_MISMATCH;
          phase_d   = PH_FAILED;
        end else begin
          phase_d = PH_DONE;
        end
      end
      KIND_ABORT: begin
        phase_d = PH_IDLE;
        tag_d   = '0;
        cnt_d   = '0;
        seq_d   = '0;
      end
      default: ;
    endcase
  end

  // Advance the session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tag_q   <= '0;
      cnt_q   <= '0;
      seq_q   <= '0;
    end else if (process) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      cnt_q   <= cnt_d;
      seq_q   <= seq_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      outcome_q   <= outcome_d;
      res_phase_q <= phase_d;
      res_cnt_q   <= cnt_d;
      res_seq_q   <= seq_d;
    end
  end

  // Pack the result word
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OutOutcomeLsb +: OutcomeW] = outcome_q;
    m_axis_tdata[OutStateLsb +: PhaseW]     = res_phase_q;
    m_axis_tdata[OutBytesLsb +: CountW]     = res_cnt_q;
    m_axis_tdata[OutSeqLsb +: CountW]       = res_seq_q;
  end

  assign m_axis_tvalid = out_valid_q;

endmodule : inorder_chunk_reassembly_check
`default_nettype wire

>>> src/icr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icr_checker: port-level checks for the in-order chunk reassembly check
// Watches the result stream and the session phase it reports.
// ----------------------------------------------------------------------------
module icr_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [icr_pkg::OutDataW-1:0]  m_axis_tdata
);
  import icr_pkg::*;

  logic [OutcomeW-1:0] outcome;
  logic [PhaseW-1:0]   phase;

  assign outcome = m_axis_tdata[OutOutcomeLsb +: OutcomeW];
  assign phase   = m_axis_tdata[OutStateLsb +: PhaseW];

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Failing outcomes leave the session failed
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (outcome == OC_OVER_CAP || outcome == OC_OVER_TOTAL ||
                      outcome == OC_SINK_FAILED || outcome == OC_LEN_MISMATCH)
    |-> phase == PH_FAILED)
    else $error("failing outcome without failed session");

  // A refusal for inactivity never reports an active session
  a_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && outcome == OC_NOT_ACTIVE |-> phase != PH_ACTIVE)
    else $error("not-active outcome with active session");

  // Idle sessions carry cleared counters
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && phase == PH_IDLE |->
      m_axis_tdata[OutBytesLsb +: CountW] == '0 &&
      m_axis_tdata[OutSeqLsb +: CountW] == '0)
    else $error("idle session with nonzero counters");

endmodule : icr_checker

bind inorder_chunk_reassembly_check icr_checker u_icr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/session_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_verdict_checker: result checker for the in-order chunk reassembly
// Watches the event, result and register write channels. Keeps its own copy
// of the session state, predicts one verdict word per accepted event and
// compares every result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module session_verdict_checker #(
  parameter int unsigned CHUNK_LENGTH_BITS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Event stream, as seen by the block
  input  wire                           s_axis_tvalid,
  input  wire                           s_axis_tready,
  // tdata: session_tag, sequence_number, byte_offset, chunk_length, sink_ok
  input  wire  [icr_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: kind
  input  wire  [icr_pkg::KindW-1:0]     s_axis_tuser,
  // Result stream, as seen by the block
  input  wire                           m_axis_tvalid,
  input  wire                           m_axis_tready,
  // tdata: outcome, session_state, bytes_received, next_sequence
  input  wire  [icr_pkg::OutDataW-1:0]  m_axis_tdata,
  // Register writes
  input  wire                           cfg_we_i,
  input  wire  [icr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire  [icr_pkg::RegW-1:0]      cfg_wdata_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);
  import icr_pkg::*;

  typedef struct packed {
    outcome_e            outcome;
    phase_e              state;
    logic [CountW-1:0]   bytes;
    logic [CountW-1:0]   next_seq;
  } verdict_t;

  verdict_t verdict_q[$];

  // Session copy and register copy
  phase_e            phase_r;
  logic [TagW-1:0]   tag_r;
  logic [CountW-1:0] bytes_r;
  logic [CountW-1:0] seq_r;
  logic [RegW-1:0]   total_r;
  logic [RegW-1:0]   cap_r;

  int mismatches = 0;
  int waiting    = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = waiting;

  // Apply one event to the session copy and return the verdict it yields
  function automatic verdict_t check_event(input kind_e kind,
                                           input logic [TagW-1:0] tag,
                                           input logic [CountW-1:0] seq,
                                           input logic [CountW-1:0] off,
                                           input logic [LenPortW-1:0] len_raw,
                                           input logic ok);
    logic [LenPortW-1:0] len;
    logic [CountW:0]     end_pos;
    outcome_e            oc;
    verdict_t            v;
    // only the low CHUNK_LENGTH_BITS bits of the length count
    for (int b = 0; b < LenPortW; b++) begin
      len[b] = (b < CHUNK_LENGTH_BITS) ? len_raw[b] : 1'b0;
    end
    end_pos = {1'b0, bytes_r} + {{(CountW + 1 - LenPortW){1'b0}}, len};
    oc = OC_ACCEPTED;
    case (kind)
      KIND_START: begin
        tag_r   = tag;
        bytes_r = '0;
        seq_r   = '0;
        phase_r = PH_ACTIVE;
      end
      KIND_CHUNK: begin
        if (phase_r != PH_ACTIVE) begin
          oc = OC_NOT_ACTIVE;
        end else if (tag != tag_r) begin
          oc = OC_WRONG_TAG;
        end else if (seq != seq_r || off != bytes_r) begin
          oc = OC_OUT_OF_ORDER;
        end else if (end_pos > {1'b0, cap_r}) begin
          oc      = OC_OVER_CAP;
          phase_r = PH_FAILED;
        end else if (total_r != '0 && end_pos > {1'b0, total_r}) begin
          oc      = OC_OVER_TOTAL;
          phase_r = PH_FAILED;
        end else if (len != '0 && !ok) begin
          oc      = OC_SINK_FAILED;
          phase_r = PH_FAILED;
        end else begin
          bytes_r = end_pos[CountW-1:0];
          seq_r   = seq_r + CountW'(1);
        end
      end
      KIND_FINISH: begin
        if (phase_r != PH_ACTIVE) begin
          oc = OC_NOT_ACTIVE;
        end else if (tag != tag_r) begin
          oc = OC_WRONG_TAG;
        end else if (total_r != '0 && bytes_r != total_r) begin
          oc      = OC_LEN_MISMATCH;
          phase_r = PH_FAILED;
        end else begin
          phase_r = PH_DONE;
        end
      end
      default: begin
        phase_r = PH_IDLE;
        tag_r   = '0;
        bytes_r = '0;
        seq_r   = '0;
      end
    endcase
    v.outcome  = oc;
    v.state    = phase_r;
    v.bytes    = bytes_r;
    v.next_seq = seq_r;
    return v;
  endfunction

  // Track writes, predict on each event word, compare on each result word
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t            want;
    logic [OutcomeW-1:0] got_oc;
    logic [PhaseW-1:0]   got_state;
    logic [CountW-1:0]   got_bytes;
    logic [CountW-1:0]   got_seq;
    if (!rst_ni) begin
      phase_r = PH_IDLE;
      tag_r   = '0;
      bytes_r = '0;
      seq_r   = '0;
      total_r = '0;
      cap_r   = '0;
      verdict_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TOTAL_LENGTH:   total_r = cfg_wdata_i;
          REG_CAPACITY_LIMIT: cap_r   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(check_event(kind_e'(s_axis_tuser),
                                        s_axis_tdata[InTagLsb +: TagW],
                                        s_axis_tdata[InSeqLsb +: CountW],
                                        s_axis_tdata[InOffLsb +: CountW],
                                        s_axis_tdata[InLenLsb +: LenPortW],
                                        s_axis_tdata[InOkBit]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no event awaiting a verdict");
          mismatches++;
        end else begin
          want      = verdict_q.pop_front();
          got_oc    = m_axis_tdata[OutOutcomeLsb +: OutcomeW];
          got_state = m_axis_tdata[OutStateLsb +: PhaseW];
          got_bytes = m_axis_tdata[OutBytesLsb +: CountW];
          got_seq   = m_axis_tdata[OutSeqLsb +: CountW];
          if (got_oc !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, got_oc);
            mismatches++;
          end
          if (got_state !== want.state) begin
            $error("session_state: expected %0d, got %0d", want.state, got_state);
            mismatches++;
          end
          if (got_bytes !== want.bytes) begin
            $error("bytes_received: expected %0d, got %0d", want.bytes, got_bytes);
            mismatches++;
          end
          if (got_seq !== want.next_seq) begin
            $error("next_sequence: expected %0d, got %0d", want.next_seq, got_seq);
            mismatches++;
          end
        end
      end
    end
    waiting = verdict_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the in-order chunk reassembly check
// Runs a directed pass over every event kind and outcome, then random upload
// sessions under several register settings, with random gaps on both sides
// and a long result stall under two of the settings. The checker module judges every result word.
// ----------------------------------------------------------------------------
module testbench;
  import icr_pkg::*;

  localparam int unsigned PhaseItems = 330;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = KIND_START;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = REG_TOTAL_LENGTH;
  logic [RegW-1:0]     cfg_wdata_i   = '0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire [OutDataW-1:0]  m_axis_tdata;

  int mismatch_count;
  int outstanding;
  int words_sent  = 0;
  int hold_cycles = 0;
  bit idle_on     = 1'b1;

  // Register values in force, and the session as the stimulus intends it
  logic [RegW-1:0]   limit_total = '0;
  logic [RegW-1:0]   limit_cap   = '0;
  logic [TagW-1:0]   sess_tag    = '0;
  logic [CountW-1:0] sess_seq    = '0;
  logic [CountW-1:0] sess_bytes  = '0;
  bit                sess_open   = 1'b0;

  inorder_chunk_reassembly_check DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  session_verdict_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: hold off while a stall is pending, else drop ready at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 25) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("inorder_chunk_reassembly_check verification failed");
    $finish;
  end

  // Offer one event word, after a random gap, and hold it until taken
  task automatic send_event(input kind_e kind, input logic [TagW-1:0] tag,
                            input logic [CountW-1:0] seq,
                            input logic [CountW-1:0] off,
                            input logic [LenPortW-1:0] len, input logic ok);
    logic [InDataW-1:0] word;
    word = '0;
    word[InTagLsb +: TagW]     = tag;
    word[InSeqLsb +: CountW]   = seq;
    word[InOffLsb +: CountW]   = off;
    word[InLenLsb +: LenPortW] = len;
    word[InOkBit]              = ok;
    while (idle_on && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Stop offering and wait until every verdict is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers while the block is idle
  task automatic set_limits(input logic [RegW-1:0] total, input logic [RegW-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_TOTAL_LENGTH;
    cfg_wdata_i <= total;
    @(posedge clk_i);
    cfg_addr_i  <= REG_CAPACITY_LIMIT;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_total = total;
    limit_cap   = cap;
  endtask

  // One upload session: a start, mostly well-formed chunks, then usually a close
  task automatic run_session();
    int                  n_chunks;
    int                  r;
    logic [LenPortW-1:0] len;
    logic                ok;
    logic [CountW:0]     end_pos;
    sess_tag = ($urandom_range(9) == 0) ? sess_tag : $urandom();
    send_event(KIND_START, sess_tag, $urandom(), $urandom(),
               LenPortW'($urandom_range(65535)), 1'($urandom_range(1)));
    sess_seq   = '0;
    sess_bytes = '0;
    sess_open  = 1'b1;
    n_chunks   = $urandom_range(1, 12);
    repeat (n_chunks) begin
      r = $urandom_range(99);
      if (r < 10) len = '0;
      else if (r < 16) len = LenPortW'($urandom_range(65535));
      else len = LenPortW'($urandom_range(1, 255));
      // land exactly on the total now and then
      if (limit_total != '0 && limit_total > sess_bytes &&
          limit_total - sess_bytes <= 65535 && $urandom_range(3) == 0) begin
        len = LenPortW'(limit_total - sess_bytes);
      end
      ok = ($urandom_range(19) != 0);
      r  = $urandom_range(99);
      if (r < 80) begin
        send_event(KIND_CHUNK, sess_tag, sess_seq, sess_bytes, len, ok);
        if (sess_open) begin
          end_pos = {1'b0, sess_bytes} + {{(CountW + 1 - LenPortW){1'b0}}, len};
          if (end_pos > {1'b0, limit_cap} ||
              (limit_total != '0 && end_pos > {1'b0, limit_total}) ||
              (len != '0 && !ok)) begin
            sess_open = 1'b0;
          end else begin
            sess_bytes = end_pos[CountW-1:0];
            sess_seq   = sess_seq + CountW'(1);
          end
        end
      end else if (r < 86) begin
        send_event(KIND_CHUNK, sess_tag ^ (32'd1 << $urandom_range(31)),
                   sess_seq, sess_bytes, len, ok);
      end else if (r < 91) begin
        send_event(KIND_CHUNK, sess_tag, $urandom(), sess_bytes, len, ok);
      end else if (r < 95) begin
        send_event(KIND_CHUNK, sess_tag, sess_seq,
                   ($urandom_range(1) != 0) ? $urandom() : sess_bytes + CountW'(1),
                   len, ok);
      end else begin
        // noise word of any kind
        send_event(kind_e'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
                   LenPortW'($urandom_range(65535)), 1'($urandom_range(1)));
        sess_open = 1'b0;
      end
    end
    r = $urandom_range(99);
    if (r < 65) begin
      send_event(KIND_FINISH, sess_tag, $urandom(), $urandom(),
                 LenPortW'($urandom_range(65535)), 1'($urandom_range(1)));
    end else if (r < 72) begin
      send_event(KIND_FINISH, ~sess_tag, sess_seq, sess_bytes, '0, 1'b1);
    end else if (r < 87) begin
      send_event(KIND_ABORT, $urandom(), $urandom(), $urandom(),
                 LenPortW'($urandom_range(65535)), 1'($urandom_range(1)));
    end
    sess_open = 1'b0;
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero capacity: idle events, empty chunk, overflow, failed session
    set_limits('0, '0);
    send_event(KIND_CHUNK, '0, '0, '0, 16'd5, 1'b1);
    send_event(KIND_FINISH, '0, '0, '0, '0, 1'b1);
    send_event(KIND_START, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send_event(KIND_CHUNK, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send_event(KIND_CHUNK, 32'hFFFF_FFFF, 32'd1, '0, 16'd1, 1'b1);
    send_event(KIND_ABORT, '0, '0, '0, '0, 1'b0);

    // Known total: tag, order and offset faults, then length, sink and total failures
    set_limits(32'd100, 32'hFFFF_FFFF);
    send_event(KIND_START, '0, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'd1, '0, '0, 16'd10, 1'b1);
    send_event(KIND_CHUNK, '0, 32'd5, '0, 16'd10, 1'b1);
    send_event(KIND_CHUNK, '0, '0, 32'd7, 16'd10, 1'b1);
    send_event(KIND_FINISH, 32'd1, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, '0, '0, '0, 16'd60, 1'b1);
    send_event(KIND_FINISH, '0, '0, '0, '0, 1'b1);
    send_event(KIND_START, 32'hA5A5_A5A5, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'hA5A5_A5A5, '0, '0, 16'd100, 1'b0);
    send_event(KIND_START, 32'h5A5A_5A5A, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'h5A5A_5A5A, '0, '0, 16'd101, 1'b1);
    send_event(KIND_START, 32'h0000_1234, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'h0000_1234, '0, '0, 16'd100, 1'b1);
    send_event(KIND_FINISH, 32'h0000_1234, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'h0000_1234, 32'd1, 32'd100, '0, 1'b1);

    // Capacity is checked ahead of the total
    set_limits(32'd40, 32'd50);
    send_event(KIND_START, 32'd77, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'd77, '0, '0, 16'd60, 1'b1);

    // Unknown total: largest chunk, finish unchecked
    set_limits('0, 32'hFFFF_FFFF);
    send_event(KIND_START, 32'h8000_0001, '0, '0, '0, 1'b1);
    send_event(KIND_CHUNK, 32'h8000_0001, '0, '0, 16'hFFFF, 1'b1);
    send_event(KIND_FINISH, 32'h8000_0001, '0, '0, '0, 1'b1);

    // Random sessions under several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_limits('0, 32'hFFFF_FFFF);
        1: set_limits($urandom_range(200, 3000), 32'hFFFF_FFFF);
        2: set_limits('0, '0);
        3: set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: set_limits($urandom_range(300, 4000), $urandom_range(200, 5000));
        default: set_limits('0, $urandom_range(500, 20000));
      endcase
      // one setting runs with no gaps at all
      idle_on = (p != 3);
      // long result stall while events keep coming
      if (p == 1 || p == 4) hold_cycles = 80;
      target = words_sent + PhaseItems;
      while (words_sent < target) run_session();
    end

    wait_drained();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("inorder_chunk_reassembly_check verification clean");
    end else begin
      $display("inorder_chunk_reassembly_check verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/icr_pkg.sv
src/inorder_chunk_reassembly_check.sv
src/icr_checker.sv
tb/session_verdict_checker.sv
tb/testbench.sv
